// File: rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked on clk_i, off while rst_ni is low
`define PMST_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked on clk_i, also checked while in reset
`define PMST_ASSERT_NR(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/pmst_pkg.sv
// package: widths, defaults and command codes of the spanning tree block
`default_nettype none

package pmst_pkg;

  localparam int unsigned DefMaxVertices = 64;
  localparam int unsigned DefWeightBits  = 16;

  localparam int unsigned VidW      = 6;
  localparam int unsigned WeightInW = 16;
  localparam int unsigned SumW      = 22;
  localparam int unsigned CountW    = 7;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_CLEAR = 2'd1,
    OP_RUN   = 2'd2
  } op_e;

endpackage

`default_nettype wire

// File: rtl/prim_minimum_spanning_tree.sv
// top level: prim spanning tree engine over an adjacency matrix of edge weights
`default_nettype none

// Usage
//   Commands enter on start/op_i with the vertex and weight fields; a command is
//   taken at a rising edge with start high and busy low. The vertex count
//   register is written over cfg_valid_i/cfg_ready_o; ready is always high and
//   the register should only change while busy is low.
//   A write command goes straight into the matrix memory. A clear command
//   sweeps the whole matrix memory of 2**(2*ceil(log2(MAX_VERTICES))) entries,
//   4096 at the default, one entry a cycle. The same sweep runs straight after
//   reset; busy is high meanwhile. A run with n vertices makes up to n-1 passes
//   over one matrix row, each reading the matrix memory once per vertex
//   1..n-1, then settling and selecting; it then reads out the parents of
//   vertices 1..n-1. Runs are bounded by the single matrix memory read port.
//   Results appear on the result ports for one cycle each, marked by
//   result_strobe_o; the readout reaches them through the pend and output
//   registers. The last word carries last_o and the total weight. A
//   disconnected graph gives one word with status_o set. The receiver cannot
//   stall the block. Results of a run may still leave after busy falls.

module prim_minimum_spanning_tree #(
  parameter int unsigned MAX_VERTICES = pmst_pkg::DefMaxVertices,
  parameter int unsigned WEIGHT_BITS  = pmst_pkg::DefWeightBits
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     op_i,
  input  wire logic [pmst_pkg::VidW-1:0]      from_vertex_i,
  input  wire logic [pmst_pkg::VidW-1:0]      to_vertex_i,
  input  wire logic [pmst_pkg::WeightInW-1:0] edge_weight_i,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [pmst_pkg::CountW-1:0]    cfg_data_i,
  output logic                                result_strobe_o,
  output logic [pmst_pkg::VidW-1:0]           vertex_id_o,
  output logic [pmst_pkg::VidW-1:0]           parent_id_o,
  output logic [pmst_pkg::SumW-1:0]           total_weight_o,
  output logic                                status_o,
  output logic                                last_o
);
  import pmst_pkg::*;

`include "assert_macros.svh"

  localparam int unsigned VW         = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned AW         = 2 * VW;
  localparam int unsigned TREE_DEPTH = 1 << VW;
  localparam int unsigned MAT_DEPTH  = 1 << AW;
  localparam logic [WEIGHT_BITS-1:0] NO_EDGE = '1;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CLEAR  = 7'b0000010,
    ST_SCAN   = 7'b0000100,
    ST_SETTLE = 7'b0001000,
    ST_SELECT = 7'b0010000,
    ST_EMIT   = 7'b0100000,
    ST_ERROR  = 7'b1000000
  } state_e;

  state_e                 state_q, state_d;
  logic [AW-1:0]          clr_q, clr_d;
  logic [CountW-1:0]      vc_q;
  logic [VW-1:0]          idx_q, idx_d;
  logic [VW-1:0]          row_q, row_d;
  logic [VW-1:0]          top_q, top_d;
  logic [VW-1:0]          top_run;
  logic                   first_q, first_d;
  logic [WEIGHT_BITS-1:0] min_q, min_d;
  logic [VW-1:0]          best_q, best_d;
  logic                   found_q, found_d;
  logic [SumW-1:0]        sum_q, sum_d;
  logic [VW-1:0]          join_q, join_d;
  logic [TREE_DEPTH-1:0]  in_tree_q, in_tree_d;
  logic                   wb_v_q, wb_v_d;
  logic [VW-1:0]          wb_idx_q, wb_idx_d;
  logic                   pend_q, pend_d;
  logic [VW-1:0]          pend_vid_q, pend_vid_d;
  logic                   pend_last_q, pend_last_d;
  logic                   err_out;

  logic                   mat_we;
  logic [AW-1:0]          mat_wa;
  logic [WEIGHT_BITS-1:0] mat_wd;
  logic [WEIGHT_BITS-1:0] mat_mem [MAT_DEPTH];
  logic [WEIGHT_BITS-1:0] mat_rd_q;
  logic [WEIGHT_BITS-1:0] dist_mem [TREE_DEPTH];
  logic [WEIGHT_BITS-1:0] dist_rd_q;
  logic [VW-1:0]          par_mem [TREE_DEPTH];
  logic [VW-1:0]          par_rd_q;

  logic [WEIGHT_BITS-1:0] d_old, d_new;
  logic [VW-1:0]          p_old, p_new;
  logic                   upd, cand, from_ok;

  logic                   out_valid_q;
  logic [VidW-1:0]        o_vid_q, o_par_q;
  logic [SumW-1:0]        o_tw_q;
  logic                   o_st_q, o_last_q;

  // clamp the vertex count to 1..MAX_VERTICES, kept as the last vertex index
  always_comb begin
    if (vc_q == '0) begin
      top_run = '0;
    end else if (vc_q > CountW'(MAX_VERTICES)) begin
      top_run = VW'(MAX_VERTICES - 1);
    end else begin
      top_run = VW'(vc_q - CountW'(1));
    end
  end

  assign from_ok = (CountW'(from_vertex_i) < CountW'(MAX_VERTICES)) &&
                   (CountW'(to_vertex_i) < CountW'(MAX_VERTICES));

  // relax one vertex against the current row, first pass starts from no edge
  always_comb begin
    d_old = first_q ? NO_EDGE : dist_rd_q;
    p_old = first_q ? '0 : par_rd_q;
    upd   = !in_tree_q[wb_idx_q] && (mat_rd_q < d_old);
    d_new = upd ? mat_rd_q : d_old;
    p_new = upd ? row_q : p_old;
    cand  = !in_tree_q[wb_idx_q] && (d_new < min_q);
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    idx_d       = idx_q;
    row_d       = row_q;
    top_d       = top_q;
    first_d     = first_q;
    min_d       = min_q;
    best_d      = best_q;
    found_d     = found_q;
    sum_d       = sum_q;
    join_d      = join_q;
    in_tree_d   = in_tree_q;
    wb_v_d      = 1'b0;
    wb_idx_d    = idx_q;
    pend_d      = 1'b0;
    pend_vid_d  = idx_q;
    pend_last_d = (idx_q == top_q);
    err_out     = 1'b0;
    mat_we      = 1'b0;
    mat_wa      = clr_q;
    mat_wd      = NO_EDGE;

    // running minimum, strict compare keeps the lowest index on a tie
    if (wb_v_q && cand) begin
      min_d   = d_new;
      best_d  = wb_idx_q;
      found_d = 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (op_i)
            OP_WRITE: begin
              if (from_ok) begin
                mat_we = 1'b1;
                mat_wa = {from_vertex_i[VW-1:0], to_vertex_i[VW-1:0]};
                mat_wd = WEIGHT_BITS'(edge_weight_i);
              end
            end
            OP_CLEAR: begin
              clr_d   = '0;
              state_d = ST_CLEAR;
            end
            OP_RUN: begin
              if (top_run != '0) begin
                top_d     = top_run;
                row_d     = '0;
                idx_d     = VW'(1);
                first_d   = 1'b1;
                min_d     = NO_EDGE;
                found_d   = 1'b0;
                sum_d     = '0;
                join_d    = '0;
                in_tree_d = '0;
                state_d   = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CLEAR: begin
        mat_we = 1'b1;
        clr_d  = clr_q + AW'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        wb_v_d = 1'b1;
        idx_d  = idx_q + VW'(1);
        if (idx_q == top_q) begin
          state_d = ST_SETTLE;
        end
      end
      ST_SETTLE: begin
        state_d = ST_SELECT;
      end
      ST_SELECT: begin
        if (!found_q) begin
          state_d = ST_ERROR;
        end else begin
          sum_d             = sum_q + SumW'(min_q);
          in_tree_d[best_q] = 1'b1;
          join_d            = join_q + VW'(1);
          idx_d             = VW'(1);
          if (join_d == top_q) begin
            state_d = ST_EMIT;
          end else begin
            row_d   = best_q;
            first_d = 1'b0;
            min_d   = NO_EDGE;
            found_d = 1'b0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_EMIT: begin
        pend_d = 1'b1;
        idx_d  = idx_q + VW'(1);
        if (idx_q == top_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_ERROR: begin
        err_out = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      vc_q        <= CountW'(1);
      first_q     <= 1'b0;
      found_q     <= 1'b0;
      in_tree_q   <= '0;
      wb_v_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      first_q     <= first_d;
      found_q     <= found_d;
      in_tree_q   <= in_tree_d;
      wb_v_q      <= wb_v_d;
      pend_q      <= pend_d;
      out_valid_q <= pend_q || err_out;
      if (cfg_valid_i) begin
        vc_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    row_q       <= row_d;
    top_q       <= top_d;
    min_q       <= min_d;
    best_q      <= best_d;
    sum_q       <= sum_d;
    join_q      <= join_d;
    wb_idx_q    <= wb_idx_d;
    pend_vid_q  <= pend_vid_d;
    pend_last_q <= pend_last_d;
    o_vid_q     <= err_out ? '0 : VidW'(pend_vid_q);
    o_par_q     <= err_out ? '0 : VidW'(par_rd_q);
    o_tw_q      <= (pend_q && pend_last_q && !err_out) ? sum_q : '0;
    o_st_q      <= err_out;
    o_last_q    <= err_out || (pend_q && pend_last_q);
  end

  // matrix memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mat_we) begin
      mat_mem[mat_wa] <= mat_wd;
    end
    mat_rd_q <= mat_mem[{row_q, idx_q}];
  end

  // distance and parent stores, written one pass step behind the read
  always_ff @(posedge clk_i) begin
    if (wb_v_q) begin
      dist_mem[wb_idx_q] <= d_new;
      par_mem[wb_idx_q]  <= p_new;
    end
    dist_rd_q <= dist_mem[idx_q];
    par_rd_q  <= par_mem[idx_q];
  end

  assign busy            = (state_q != ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign result_strobe_o = out_valid_q;
  assign vertex_id_o     = o_vid_q;
  assign parent_id_o     = o_par_q;
  assign total_weight_o  = o_tw_q;
  assign status_o        = o_st_q;
  assign last_o          = o_last_q;

  `PMST_ASSERT(a_err_word, result_strobe_o && status_o |-> last_o && (total_weight_o == '0), "error word malformed")
  `PMST_ASSERT(a_last_alone, result_strobe_o && last_o |=> !result_strobe_o, "word after final word")
  `PMST_ASSERT(a_best_outside, (state_q == ST_SELECT) && found_q |-> !in_tree_q[best_q], "selected vertex already in tree")
  `PMST_ASSERT(a_scan_range, (state_q == ST_SCAN) |-> (idx_q != '0) && (idx_q <= top_q), "scan index out of range")
  `PMST_ASSERT_NR(a_reset_quiet, !rst_ni |=> !result_strobe_o, "word right after reset")

endmodule

`default_nettype wire

// File: verif/prim_minimum_spanning_tree_test.sv
// testbench: spanning tree engine checked word by word against a tree predictor
`default_nettype none

module prim_minimum_spanning_tree_test;
  import pmst_pkg::*;

  localparam int unsigned MaxVertices = DefMaxVertices;
  localparam logic [WeightInW-1:0] NoEdge = '1;
  localparam logic [1:0] OpUnused = 2'd3;
  localparam int unsigned TailCycles = 8;
  localparam int unsigned QuietLimit = 50000;
  localparam int unsigned WordTarget = 260;

  typedef struct packed {
    logic [VidW-1:0] vertex;
    logic [VidW-1:0] parent;
    logic [SumW-1:0] total;
    logic            status;
    logic            last_word;
  } tree_word_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           op_i = OP_WRITE;
  logic [VidW-1:0]      from_vertex_i = '0;
  logic [VidW-1:0]      to_vertex_i = '0;
  logic [WeightInW-1:0] edge_weight_i = '0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CountW-1:0]    cfg_data_i = '0;
  logic                 result_strobe_o;
  logic [VidW-1:0]      vertex_id_o;
  logic [VidW-1:0]      parent_id_o;
  logic [SumW-1:0]      total_weight_o;
  logic                 status_o;
  logic                 last_o;

  // shadow of the block state
  logic [WeightInW-1:0] edge_table [MaxVertices][MaxVertices];
  logic [CountW-1:0]    count_shadow = 7'd1;
  tree_word_t           parents_due [$];

  tree_word_t got_word;
  tree_word_t due_word;
  int         fault_count = 0;
  int         words_sent = 0;
  int         quiet_cycles = 0;
  bit         sender_quiet = 1'b0;

  prim_minimum_spanning_tree i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .from_vertex_i  (from_vertex_i),
    .to_vertex_i    (to_vertex_i),
    .edge_weight_i  (edge_weight_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .result_strobe_o(result_strobe_o),
    .vertex_id_o    (vertex_id_o),
    .parent_id_o    (parent_id_o),
    .total_weight_o (total_weight_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic wipe_table();
    for (int r = 0; r < MaxVertices; r++) begin
      for (int c = 0; c < MaxVertices; c++) edge_table[r][c] = NoEdge;
    end
  endtask

  // grow the tree from vertex 0 and queue the words it should report
  task automatic grow_tree();
    int                   n;
    int                   pick;
    logic [WeightInW-1:0] lowest;
    logic [WeightInW-1:0] reach [MaxVertices];
    logic [VidW-1:0]      par [MaxVertices];
    bit                   joined [MaxVertices];
    logic [SumW:0]        sum;
    tree_word_t           w;
    n = (count_shadow == 0) ? 1 : (count_shadow > MaxVertices) ? MaxVertices : count_shadow;
    if (n < 2) return;
    sum = '0;
    for (int i = 0; i < n; i++) begin
      reach[i] = edge_table[0][i];
      par[i] = '0;
      joined[i] = (i == 0);
    end
    for (int s = 1; s < n; s++) begin
      pick = 0;
      lowest = NoEdge;
      for (int i = 1; i < n; i++) begin
        if (!joined[i] && reach[i] < lowest) begin
          lowest = reach[i];
          pick = i;
        end
      end
      // nothing reachable: a single error word
      if (pick == 0) begin
        w = '0;
        w.status = 1'b1;
        w.last_word = 1'b1;
        parents_due.push_back(w);
        return;
      end
      sum += lowest;
      joined[pick] = 1'b1;
      for (int i = 1; i < n; i++) begin
        if (!joined[i] && edge_table[pick][i] < reach[i]) begin
          reach[i] = edge_table[pick][i];
          par[i] = VidW'(pick);
        end
      end
    end
    for (int i = 1; i < n; i++) begin
      w.vertex = VidW'(i);
      w.parent = par[i];
      w.total = (i == n - 1) ? sum[SumW-1:0] : '0;
      w.status = 1'b0;
      w.last_word = (i == n - 1);
      parents_due.push_back(w);
    end
  endtask

  task automatic apply_command(input logic [1:0] op, input logic [VidW-1:0] src,
                               input logic [VidW-1:0] dst, input logic [WeightInW-1:0] w);
    case (op)
      OP_WRITE: edge_table[src][dst] = w;
      OP_CLEAR: wipe_table();
      OP_RUN:   grow_tree();
      default: ;
    endcase
  endtask

  function automatic logic [WeightInW-1:0] draw_weight(input bit real_edge);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) return WeightInW'($urandom_range(0, 3));
    if (roll < 40) begin
      case ($urandom_range(0, 2))
        0: return '0;
        1: return WeightInW'(1);
        default: return NoEdge - 1'b1;
      endcase
    end
    if (roll < 95 || real_edge) return WeightInW'($urandom_range(0, 16'hfffe));
    return NoEdge;
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [VidW-1:0] src,
                           input logic [VidW-1:0] dst, input logic [WeightInW-1:0] w);
    if (!sender_quiet && $urandom_range(0, 99) < 3) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start <= 1'b1;
    op_i <= op;
    from_vertex_i <= src;
    to_vertex_i <= dst;
    edge_weight_i <= w;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    apply_command(op, src, dst, w);
    if (op != OpUnused) words_sent++;
  endtask

  // run fields are don't-care, so drive them at random
  task automatic send_run();
    send_word(OP_RUN, VidW'($urandom), VidW'($urandom), WeightInW'($urandom));
  endtask

  // hold the sender until the block is idle and every expected word is in
  task automatic settle_block();
    start <= 1'b0;
    @(posedge clk_i);
    while (parents_due.size() != 0 || busy !== 1'b0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [CountW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    count_shadow = value;
  endtask

  task automatic test_single_vertex();
    send_run();
    settle_block();
    write_count(7'd0);
    send_run();
  endtask

  task automatic test_weight_extremes();
    settle_block();
    write_count(7'd2);
    send_word(OP_WRITE, 6'd0, 6'd1, NoEdge - 1'b1);
    send_word(OP_WRITE, 6'd1, 6'd0, NoEdge - 1'b1);
    send_run();
    send_word(OP_WRITE, 6'd0, 6'd1, '0);
    send_run();
    send_word(OP_WRITE, 6'd0, 6'd1, NoEdge);
    send_run();
  endtask

  task automatic test_one_way_edges();
    settle_block();
    write_count(7'd3);
    send_word(OP_WRITE, 6'd0, 6'd1, 16'd5);
    send_word(OP_WRITE, 6'd1, 6'd2, 16'd3);
    send_run();
  endtask

  // equal distances: lowest index joins first, equal relax keeps the parent
  task automatic test_equal_weights();
    send_word(OP_WRITE, 6'd0, 6'd2, 16'd5);
    send_word(OP_WRITE, 6'd1, 6'd2, 16'd5);
    send_run();
  endtask

  task automatic test_ignored_words();
    send_word(OpUnused, '1, '1, '1);
    send_word(OP_WRITE, 6'd63, 6'd63, 16'h8000);
    settle_block();
    write_count(7'd127);
    send_run();
  endtask

  task automatic test_clear();
    send_word(OP_CLEAR, '1, '0, '1);
    settle_block();
    write_count(7'd2);
    send_run();
  endtask

  task automatic test_full_size();
    int                   a;
    int                   b;
    logic [WeightInW-1:0] w;
    settle_block();
    write_count(7'd64);
    for (int i = 1; i < MaxVertices; i++) send_word(OP_WRITE, '0, VidW'(i), draw_weight(1'b1));
    repeat (16) begin
      a = $urandom_range(1, MaxVertices - 1);
      b = $urandom_range(1, MaxVertices - 1);
      w = draw_weight(1'b0);
      send_word(OP_WRITE, VidW'(a), VidW'(b), w);
      send_word(OP_WRITE, VidW'(b), VidW'(a), w);
    end
    send_run();
  endtask

  // one graph: mostly a connected tree plus extra edges, sometimes only noise
  task automatic random_graph();
    int                   roll;
    int                   n;
    int                   a;
    int                   b;
    bit                   broken;
    logic [CountW-1:0]    setting;
    logic [WeightInW-1:0] w;
    roll = $urandom_range(0, 99);
    if (roll < 8) setting = CountW'($urandom_range(0, 1));
    else if (roll < 80) setting = CountW'($urandom_range(2, 10));
    else if (roll < 97) setting = CountW'($urandom_range(11, 20));
    else setting = CountW'($urandom_range(65, 127));
    n = (setting == 0) ? 1 : (setting > MaxVertices) ? MaxVertices : setting;
    if (setting != count_shadow) begin
      settle_block();
      write_count(setting);
    end
    if ($urandom_range(0, 9) == 0) send_word(OP_CLEAR, VidW'($urandom), VidW'($urandom),
                                             WeightInW'($urandom));
    broken = (n > 20) || ($urandom_range(0, 99) < 15);
    if (!broken) begin
      for (int i = 1; i < n; i++) begin
        a = $urandom_range(0, i - 1);
        w = draw_weight(1'b1);
        send_word(OP_WRITE, VidW'(a), VidW'(i), w);
        send_word(OP_WRITE, VidW'(i), VidW'(a), w);
      end
    end
    repeat ($urandom_range(0, (n > 12) ? 12 : n)) begin
      a = $urandom_range(0, n - 1);
      b = $urandom_range(0, n - 1);
      w = draw_weight(1'b0);
      send_word(OP_WRITE, VidW'(a), VidW'(b), w);
      // one-way edge now and then
      if ($urandom_range(0, 3) != 0) send_word(OP_WRITE, VidW'(b), VidW'(a), w);
    end
    if ($urandom_range(0, 19) == 0) send_word(OpUnused, VidW'($urandom), VidW'($urandom),
                                              WeightInW'($urandom));
    send_run();
  endtask

  task automatic test_random_graphs(input int target);
    while (words_sent < target) random_graph();
  endtask

  task automatic test_back_to_back(input int extra);
    int goal;
    goal = words_sent + extra;
    sender_quiet = 1'b1;
    while (words_sent < goal) random_graph();
    sender_quiet = 1'b0;
  endtask

  initial begin
    wipe_table();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_single_vertex();
    test_weight_extremes();
    test_one_way_edges();
    test_equal_weights();
    test_ignored_words();
    test_clear();
    test_random_graphs(80);
    test_full_size();
    test_back_to_back(50);
    test_random_graphs(WordTarget);
    settle_block();
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o === 1'b1) begin
      got_word = {vertex_id_o, parent_id_o, total_weight_o, status_o, last_o};
      if (parents_due.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected word: vertex %0d parent %0d total %0d status %0b last %0b",
                   got_word.vertex, got_word.parent, got_word.total, got_word.status,
                   got_word.last_word);
      end else begin
        due_word = parents_due.pop_front();
        if (got_word.vertex !== due_word.vertex || got_word.parent !== due_word.parent ||
            got_word.total !== due_word.total || got_word.status !== due_word.status ||
            got_word.last_word !== due_word.last_word) begin
          fault_count++;
          if (fault_count <= 10)
            $display("mismatch: expected v %0d p %0d sum %0d st %0b last %0b, got v %0d p %0d sum %0d st %0b last %0b",
                     due_word.vertex, due_word.parent, due_word.total, due_word.status,
                     due_word.last_word, got_word.vertex, got_word.parent, got_word.total,
                     got_word.status, got_word.last_word);
        end
      end
    end
  end

  // a clear or a full-size run keeps the block quiet for less than QuietLimit; longer quiet fails the run
  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || (cfg_valid_i && cfg_ready_o === 1'b1) ||
        result_strobe_o === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

`default_nettype wire
